>>> hw/rtl/packed_nibble_frame_deframer_top_macros.svh
// assertion macros for the packed nibble frame deframer checker
`ifndef PACKED_NIBBLE_FRAME_DEFRAMER_TOP_MACROS_SVH
`define PACKED_NIBBLE_FRAME_DEFRAMER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PNFD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PNFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/pnfd_pkg.sv
// shared types, constants and palette for the packed nibble frame deframer
package pnfd_pkg;

  localparam int FRAME_WIDTH  = 400;
  localparam int FRAME_HEIGHT = 240;
  localparam int PACKET_WORDS = 16;

  localparam logic [31:0] SYNC_WORD = 32'hbbbbbbbb;
  localparam int PIX_PER_WORD = 8;

  // internal widths
  localparam int COL_W  = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int COL_W1 = COL_W + 1;
  localparam int ROW_W  = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
  localparam int PKT_W  = (PACKET_WORDS > 1) ? $clog2(PACKET_WORDS) : 1;
  localparam int FRAME_PIX = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int REM_W  = $clog2(FRAME_PIX + 1);

  // position right after the sync packet
  localparam int SYNC_PIX  = PACKET_WORDS * PIX_PER_WORD;
  localparam int SYNC_COL  = SYNC_PIX % FRAME_WIDTH;
  localparam int SYNC_ROW  = SYNC_PIX / FRAME_WIDTH;
  localparam bit SYNC_FITS = (SYNC_ROW < FRAME_HEIGHT);
  localparam int REM_START = SYNC_FITS ? (FRAME_PIX - SYNC_PIX) : 0;

  // queue between front and back, depth a power of two
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // port widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  // one captured word and how to emit it
  typedef struct packed {
    logic [31:0]      data_word;
    logic [COL_W-1:0] start_col;
    logic [ROW_W-1:0] start_row;
    logic [2:0]       last_k;      // nibble slot of the last emitted pixel
    logic             last_en;     // word_last allowed on last_k
    logic             fend;        // frame ends on last_k
  } entry_t;

  // fixed 16-color palette, {red, green, blue}
  function automatic logic [23:0] pal_rgb(input logic [3:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'd1:    rgb = {8'h2b, 8'h2b, 8'h2b};
      4'd3:    rgb = {8'h60, 8'h60, 8'h60};
      4'd6:    rgb = {8'd20, 8'd130, 8'd218};
      4'd11:   rgb = {8'h40, 8'h40, 8'h40};
      4'd12:   rgb = {8'd0, 8'd200, 8'd80};
      4'd13:   rgb = {8'd200, 8'd170, 8'd0};
      4'd14:   rgb = {8'd200, 8'd0, 8'd100};
      4'd15:   rgb = {8'd255, 8'd255, 8'd255};
      default: rgb = 24'd0;
    endcase
    return rgb;
  endfunction

endpackage

>>> hw/rtl/packed_nibble_frame_deframer_top.sv
// Packed nibble frame deframer. Link words arrive one per request on the in_ side; while
// hunting every word is always taken and yields nothing, until a full packet of
// sync words places capture just past the sync pixels. Each captured word then yields up to
// eight pixels, one per cycle unless out_tready stalls the output, each with its raster
// position, palette index and color; pixels leave through the single pixel output register.
// The front end takes a new word in the next cycle as long as the two-entry queue has
// room, so a stalled output side holds at most two queued words plus the pixel being
// shown. After the last pixel of the frame (out_tlast) the block hunts for sync again;
// pixels after the frame end are dropped.
module packed_nibble_frame_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] data_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [8:0] pixel_x, [16:9] pixel_y, [20:17] palette_index,
                                   // [28:21] red, [36:29] green, [44:37] blue, rest zero
  output logic        out_tuser,   // [0] word_last
  output logic        out_tlast    // frame_end
);
  import pnfd_pkg::*;

  entry_t push_entry, head;
  logic   push, pop, head_valid, q_full;

  // sync hunt and word classification
  pnfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (push),
    .q_entry   (push_entry)
  );

  // decoupling queue
  pnfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  // pixel emission
  pnfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> hw/rtl/pnfd_front.sv
// front end: sync hunt, frame position tracking and per-word classification
module pnfd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [31:0]      in_tdata,
  input  logic             q_full,
  output logic             q_push,
  output pnfd_pkg::entry_t q_entry
);
  import pnfd_pkg::*;

  logic             hunting_r, hunting_nxt;
  logic [PKT_W-1:0] wip_r, wip_nxt;
  logic             all_sync_r, all_sync_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;

  logic              accept;
  logic              all_now;
  logic              rem_ge8, rem_le8;
  logic [COL_W1-1:0] col_sum;

  // hunting words never queue, so they are always taken
  assign in_tready = hunting_r | ~q_full;
  assign accept    = in_tvalid & in_tready;
  assign q_push    = accept & ~hunting_r;

  assign all_now = all_sync_r & (in_tdata == SYNC_WORD);
  assign rem_ge8 = (rem_r >= REM_W'(PIX_PER_WORD));
  assign rem_le8 = (rem_r <= REM_W'(PIX_PER_WORD));
  assign col_sum = {1'b0, col_r} + COL_W1'(PIX_PER_WORD);

  // entry for the back end
  always_comb begin
    q_entry.data_word = in_tdata;
    q_entry.start_col = col_r;
    q_entry.start_row = row_r;
    q_entry.last_k    = rem_ge8 ? 3'd7 : 3'(rem_r - REM_W'(1));
    q_entry.last_en   = rem_ge8;
    q_entry.fend      = rem_le8;
  end

  // next state
  always_comb begin
    hunting_nxt  = hunting_r;
    wip_nxt      = wip_r;
    all_sync_nxt = all_sync_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    rem_nxt      = rem_r;
    if (accept) begin
      if (hunting_r) begin
        if (wip_r == PKT_W'(PACKET_WORDS - 1)) begin
          wip_nxt      = '0;
          all_sync_nxt = 1'b1;
          if (all_now && SYNC_FITS) begin
            hunting_nxt = 1'b0;
            col_nxt     = COL_W'(SYNC_COL);
            row_nxt     = ROW_W'(SYNC_ROW);
            rem_nxt     = REM_W'(REM_START);
          end
        end else begin
          wip_nxt      = wip_r + PKT_W'(1);
          all_sync_nxt = all_now;
        end
      end else if (rem_le8) begin
        // frame done with this word
        hunting_nxt  = 1'b1;
        wip_nxt      = '0;
        all_sync_nxt = 1'b1;
        col_nxt      = '0;
        row_nxt      = '0;
      end else begin
        rem_nxt = rem_r - REM_W'(PIX_PER_WORD);
        if (col_sum >= COL_W1'(FRAME_WIDTH)) begin
          col_nxt = COL_W'(col_sum - COL_W1'(FRAME_WIDTH));
          row_nxt = row_r + ROW_W'(1);
        end else begin
          col_nxt = COL_W'(col_sum);
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunting_r  <= 1'b1;
      wip_r      <= '0;
      all_sync_r <= 1'b1;
      col_r      <= '0;
      row_r      <= '0;
      rem_r      <= '0;
    end else begin
      hunting_r  <= hunting_nxt;
      wip_r      <= wip_nxt;
      all_sync_r <= all_sync_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      rem_r      <= rem_nxt;
    end
  end

endmodule

>>> hw/rtl/pnfd_queue.sv
// two-entry word queue between front and back end
module pnfd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pnfd_pkg::entry_t push_entry,
  input  logic             pop,
  output pnfd_pkg::entry_t head,
  output logic             head_valid,
  output logic             full
);
  import pnfd_pkg::*;

  entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign head       = mem_r[rd_ptr_r];
  assign head_valid = (cnt_r != '0);
  assign full       = (cnt_r == QCNT_W'(QDEPTH));

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> hw/rtl/pnfd_back.sv
// back end: nibble walk, palette lookup and output register
module pnfd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  pnfd_pkg::entry_t head,
  input  logic             head_valid,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [47:0]      out_tdata,
  output logic             out_tuser,
  output logic             out_tlast
);
  import pnfd_pkg::*;

  logic [2:0]       k_r, k_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [8:0]  x_r;
  logic [7:0]  y_r;
  logic [3:0]  idx_r;
  logic [23:0] rgb_r;
  logic        wl_r, fe_r;

  logic              adv, emit, at_last;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W1-1:0] col_inc;
  logic [3:0]        nib;

  // output register frees when empty or taken
  assign adv     = ~out_valid_r | out_tready;
  assign emit    = adv & head_valid;
  assign at_last = (k_r == head.last_k);
  assign pop     = emit & at_last;

  // first nibble of a word starts from the queued position
  assign cur_col = (k_r == 3'd0) ? head.start_col : col_r;
  assign cur_row = (k_r == 3'd0) ? head.start_row : row_r;
  assign col_inc = {1'b0, cur_col} + COL_W1'(1);

  // nibble order 3,2,1,0,7,6,5,4
  assign nib = head.data_word[{k_r[2], ~k_r[1:0], 2'b00} +: 4];

  // walk state
  always_comb begin
    k_nxt         = k_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    out_valid_nxt = adv ? head_valid : 1'b1;
    if (emit) begin
      k_nxt = at_last ? 3'd0 : k_r + 3'd1;
      if (col_inc >= COL_W1'(FRAME_WIDTH)) begin
        col_nxt = '0;
        row_nxt = cur_row + ROW_W'(1);
      end else begin
        col_nxt = COL_W'(col_inc);
        row_nxt = cur_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= 3'd0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // pixel payload
  always_ff @(posedge clk) begin
    if (emit) begin
      x_r   <= 9'(cur_col);
      y_r   <= 8'(cur_row);
      idx_r <= nib;
      rgb_r <= pal_rgb(nib);
      wl_r  <= head.last_en & at_last;
      fe_r  <= head.fend & at_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, rgb_r[7:0], rgb_r[15:8], rgb_r[23:16], idx_r, y_r, x_r};
  assign out_tuser  = wl_r;
  assign out_tlast  = fe_r;

endmodule

>>> hw/rtl/pnfd_checker.sv
// port-level checks for the packed nibble frame deframer, bound to the top level
`include "packed_nibble_frame_deframer_top_macros.svh"

module pnfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);
  import pnfd_pkg::*;

  // a stalled pixel request holds
  `PNFD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast),
    "stalled pixel request changed")

  // frame end lands on the bottom right pixel
  `PNFD_ASSERT_IMPL(a_fend_pos, out_tvalid && out_tlast,
    out_tdata[8:0] == 9'(FRAME_WIDTH - 1) && out_tdata[16:9] == 8'(FRAME_HEIGHT - 1),
    "frame end not at last pixel")

  // column stays inside the frame
  `PNFD_ASSERT_IMPL(a_col_range, out_tvalid, out_tdata[8:0] < 9'(FRAME_WIDTH), "pixel column out of range")

  // row stays inside the frame
  `PNFD_ASSERT_IMPL(a_row_range, out_tvalid, out_tdata[16:9] < 8'(FRAME_HEIGHT), "pixel row out of range")

endmodule

bind packed_nibble_frame_deframer_top pnfd_checker u_pnfd_checker (.*);

>>> sim/tb.sv
// self-checking testbench for the packed nibble frame deframer
`timescale 1ns / 100ps

module tb;
  import pnfd_pkg::FRAME_WIDTH;
  import pnfd_pkg::FRAME_HEIGHT;
  import pnfd_pkg::PACKET_WORDS;
  import pnfd_pkg::SYNC_WORD;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int TAIL_CYCLES = 24;
  localparam int MAX_REPORTS = 200;

  // palette entries packed {red, green, blue}, entry 0 in the lowest bits
  localparam logic [16*24-1:0] COLOR_MAP = {
    24'hffffff, 24'hc80064, 24'hc8aa00, 24'h00c850,
    24'h404040, 24'h000000, 24'h000000, 24'h000000,
    24'h000000, 24'h1482da, 24'h000000, 24'h000000,
    24'h606060, 24'h000000, 24'h2b2b2b, 24'h000000
  };

  // one expected pixel
  typedef struct {
    logic [8:0] px;
    logic [7:0] py;
    logic [3:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    bit         word_last;
    bit         frame_end;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  packed_nibble_frame_deframer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  // stimulus and expectation stores
  logic [31:0] link_words[$];
  pixel_t      due_pixels[$];
  int          words_queued = 0;
  int          words_taken = 0;
  int          fail_cnt = 0;
  int          hunt_pos = 0;
  int          in_level = 0;
  int          out_level = 0;
  int          word_gap = 0;
  int          pix_stall = 0;
  int          cycle_cnt = 0;

  // deframer state as seen by the predictor
  bit          seeking = 1'b1;
  int          pkt_pos = 0;
  bit          pkt_sync = 1'b1;
  int          cur_col = 0;
  int          cur_row = 0;

  // idle length: level 0 none, 1 light, 2 mostly short with a few long
  function automatic int pick_gap(input int level);
    int r;
    r = $urandom_range(0, 99);
    if (level == 0 || r < 55) return 0;
    if (level == 1 || r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [31:0] rand_non_sync();
    logic [31:0] w;
    w = $urandom;
    if (w == SYNC_WORD) w[0] = ~w[0];
    return w;
  endfunction

  // advance the deframer by one link word, queue the pixels it yields
  task automatic unpack_word(input logic [31:0] w);
    pixel_t     p;
    int         k;
    int         shift;
    bit         done;
    logic [3:0] nib;
    done = 1'b0;
    if (seeking) begin
      if (w != SYNC_WORD) pkt_sync = 1'b0;
      pkt_pos++;
      if (pkt_pos >= PACKET_WORDS) begin
        pkt_pos = 0;
        if (pkt_sync) begin
          cur_col = (PACKET_WORDS * 8) % FRAME_WIDTH;
          cur_row = (PACKET_WORDS * 8) / FRAME_WIDTH;
          if (cur_row < FRAME_HEIGHT) begin
            seeking = 1'b0;
          end else begin
            cur_col = 0;
            cur_row = 0;
          end
        end
        pkt_sync = 1'b1;
      end
    end else begin
      for (k = 0; k < 8 && !done; k++) begin
        // low half first, top nibble of each half first
        shift = (k < 4) ? 12 - 4 * k : 44 - 4 * k;
        nib = w[shift +: 4];
        p.px = cur_col[8:0];
        p.py = cur_row[7:0];
        p.idx = nib;
        {p.red, p.green, p.blue} = COLOR_MAP[nib * 24 +: 24];
        p.word_last = (k == 7);
        cur_col++;
        if (cur_col >= FRAME_WIDTH) begin
          cur_col = 0;
          cur_row++;
        end
        p.frame_end = (cur_row >= FRAME_HEIGHT);
        // a frame ending early in the word never reaches the eighth pixel
        due_pixels.push_back(p);
        if (p.frame_end) begin
          done = 1'b1;
          cur_col = 0;
          cur_row = 0;
          seeking = 1'b1;
          pkt_pos = 0;
          pkt_sync = 1'b1;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic queue_word(input logic [31:0] w);
    link_words.push_back(w);
    words_queued++;
  endtask

  // word sent while the block hunts, keeps track of the packet slot
  task automatic queue_hunt_word(input logic [31:0] w);
    queue_word(w);
    hunt_pos = (hunt_pos + 1) % PACKET_WORDS;
  endtask

  // fill the current packet with noise, then one clean sync packet
  task automatic queue_sync_packet();
    int i;
    while (hunt_pos != 0) queue_hunt_word(rand_non_sync());
    for (i = 0; i < PACKET_WORDS; i++) queue_hunt_word(SYNC_WORD);
  endtask

  // wait until every word is taken and every pixel has come out
  task automatic settle();
    while (words_taken != words_queued || due_pixels.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pixels();
    logic [3:0] nib;
    nib = $urandom_range(0, 15);
    case ($urandom_range(0, 7))
      0:       return SYNC_WORD;
      1:       return {8{nib}};
      default: return $urandom;
    endcase
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      word_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        unpack_word(in_tdata);
        words_taken++;
        word_gap = pick_gap(in_level);
      end
      if (in_tvalid && !in_tready) begin
        // hold the request until taken
      end else if (word_gap > 0) begin
        word_gap--;
        in_tvalid <= 1'b0;
      end else if (link_words.size() > 0) begin
        in_tdata <= link_words.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // pixel monitor and checker
  always @(posedge clk) begin
    pixel_t exp_pix;
    if (!rst_n) begin
      out_tready <= 1'b0;
      pix_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_pixels.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("%0t: unexpected pixel, expected none, got x=%0d y=%0d idx=%0d",
                     $time, out_tdata[8:0], out_tdata[16:9], out_tdata[20:17]);
        end else begin
          exp_pix = due_pixels.pop_front();
          check_field("pixel_x", exp_pix.px, out_tdata[8:0]);
          check_field("pixel_y", exp_pix.py, out_tdata[16:9]);
          check_field("palette_index", exp_pix.idx, out_tdata[20:17]);
          check_field("red", exp_pix.red, out_tdata[28:21]);
          check_field("green", exp_pix.green, out_tdata[36:29]);
          check_field("blue", exp_pix.blue, out_tdata[44:37]);
          check_field("tdata padding", 0, out_tdata[47:45]);
          check_field("word_last", exp_pix.word_last, out_tuser);
          check_field("frame_end", exp_pix.frame_end, out_tlast);
        end
        pix_stall = pick_gap(out_level);
      end
      if (pix_stall > 0) begin
        pix_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // stimulus
  initial begin
    int i;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: a packet spoiled by non-sync words, then a clean sync packet
    in_level = 2;
    out_level = 2;
    queue_hunt_word(32'h00000000);
    queue_hunt_word(32'hffffffff);
    for (i = 0; i < PACKET_WORDS - 3; i++) queue_hunt_word(SYNC_WORD);
    queue_hunt_word(SYNC_WORD ^ 32'h1);
    queue_sync_packet();
    // every palette entry, all-zero and all-one words, a sync word while capturing
    queue_word(32'h01234567);
    queue_word(32'h89abcdef);
    queue_word(32'h00000000);
    queue_word(32'hffffffff);
    queue_word(SYNC_WORD);

    // sender holds off until the output side has drained
    settle();

    // random words within the frame, idling changes every stretch
    for (i = 0; i < 160; i++) begin
      if (i % 20 == 0) begin
        in_level = ($urandom_range(0, 4) == 0) ? 0 : 2;
        out_level = ($urandom_range(0, 4) == 0) ? 0 : 2;
      end
      queue_word(rand_pixels());
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
